// ===== rtl/slcan_pkg.sv =====
// Shared types, constants and a helper function for the serial-line CAN frame text encoder.
// No dependencies.
`default_nettype none

package slcan_pkg;

    localparam int unsigned ID_W      = 29;
    localparam int unsigned DLC_W     = 4;
    localparam int unsigned PAYLOAD_W = 64;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned ID_SH_W   = 32;
    localparam int unsigned CNT_W     = 4;

    localparam logic [CNT_W-1:0] STD_DIGITS = 4'd3;
    localparam logic [CNT_W-1:0] EXT_DIGITS = 4'd8;
    localparam logic [CNT_W-1:0] MAX_BYTES  = 4'd8;

    localparam logic [CHAR_W-1:0] CHAR_STD_DATA = 8'h74; // 't'
    localparam logic [CHAR_W-1:0] CHAR_STD_RTR  = 8'h72; // 'r'
    localparam logic [CHAR_W-1:0] CHAR_EXT_DATA = 8'h54; // 'T'
    localparam logic [CHAR_W-1:0] CHAR_EXT_RTR  = 8'h52; // 'R'
    localparam logic [CHAR_W-1:0] CHAR_CR       = 8'h0d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A_MINUS_10 = 8'h37;

    typedef struct packed {
        logic [ID_W-1:0]      can_id;
        logic                 extended;
        logic                 remote;
        logic [DLC_W-1:0]     length_code;
        logic [PAYLOAD_W-1:0] payload;
    } frame_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_t;

    // classified frame handed from front to back
    typedef struct packed {
        logic [CHAR_W-1:0]    letter;
        logic [ID_SH_W-1:0]   id_sh;
        logic [CNT_W-1:0]     id_cnt;
        logic [DLC_W-1:0]     dlc;
        logic [CNT_W-1:0]     nbytes;
        logic [PAYLOAD_W-1:0] payload;
    } desc_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LETTER,
        PH_ID,
        PH_DLC,
        PH_DATA,
        PH_CR
    } phase_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
        logic [CHAR_W-1:0] ext_v;
        ext_v = {4'b0, v};
        return (v < 4'd10) ? (ext_v + CHAR_ZERO) : (ext_v + CHAR_A_MINUS_10);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/slcan_front.sv =====
// Front end: accepts frames, holds the enable register, classifies each frame into a descriptor.
// Depends on slcan_pkg.
`default_nettype none

module slcan_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_valid,
    input  wire logic            cfg_data,
    input  wire logic            frame_valid,
    output logic                 frame_stall,
    input  wire slcan_pkg::frame_t frame,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output slcan_pkg::desc_t     push_desc
);
    import slcan_pkg::*;

    logic   enable_reg;
    logic   valid_reg, valid_next;
    desc_t  desc_reg, desc_next;
    logic   accept;
    logic   push;
    desc_t  cls;

    always_comb
    begin
        cls.letter  = frame.extended ? (frame.remote ? CHAR_EXT_RTR : CHAR_EXT_DATA)
                                     : (frame.remote ? CHAR_STD_RTR : CHAR_STD_DATA);
        cls.id_sh   = frame.extended ? {3'b0, frame.can_id} : {frame.can_id[11:0], 20'b0};
        cls.id_cnt  = frame.extended ? EXT_DIGITS : STD_DIGITS;
        cls.dlc     = frame.length_code;
        cls.nbytes  = frame.remote ? '0 :
                      ((frame.length_code > MAX_BYTES) ? MAX_BYTES : frame.length_code);
        cls.payload = frame.payload;
    end

    assign push        = valid_reg && push_ready;
    assign frame_stall = valid_reg && !push_ready;
    assign accept      = frame_valid && !frame_stall;
    assign push_valid  = valid_reg;
    assign push_desc   = desc_reg;

    always_comb
    begin
        valid_next = valid_reg && !push;
        desc_next  = desc_reg;
        if (accept && enable_reg)
        begin
            valid_next = 1'b1;
            desc_next  = cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                enable_reg <= cfg_data;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule

`default_nettype wire

// ===== rtl/slcan_fifo.sv =====
// Two-entry descriptor queue between front and back.
// Depends on slcan_pkg.
`default_nettype none

module slcan_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire slcan_pkg::desc_t push_desc,
    output logic                  pop_valid,
    input  wire logic             pop,
    output slcan_pkg::desc_t      pop_desc
);
    import slcan_pkg::*;

    desc_t       mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_desc   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

`default_nettype wire

// ===== rtl/slcan_back.sv =====
// Back end: walks a descriptor character by character into a registered output stage.
// Depends on slcan_pkg.
`default_nettype none

module slcan_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pop_valid,
    output logic                  pop,
    input  wire slcan_pkg::desc_t pop_desc,
    output logic                  text_valid,
    input  wire logic             text_stall,
    output slcan_pkg::text_t      text
);
    import slcan_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [CHAR_W-1:0]     letter_reg, letter_next;
    logic [ID_SH_W-1:0]    id_sh_reg, id_sh_next;
    logic [CNT_W-1:0]      id_cnt_reg, id_cnt_next;
    logic [DLC_W-1:0]      dlc_reg, dlc_next;
    logic [CNT_W-1:0]      nb_reg, nb_next;
    logic [PAYLOAD_W-1:0]  pay_reg, pay_next;
    logic                  hi_reg, hi_next;
    logic                  out_valid_reg, out_valid_next;
    text_t                 out_reg, out_next;
    logic                  advance;
    logic                  load;
    text_t                 cur;

    assign advance    = (phase_reg != PH_IDLE) && (!out_valid_reg || !text_stall);
    assign text_valid = out_valid_reg;
    assign text       = out_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        letter_next = letter_reg;
        id_sh_next  = id_sh_reg;
        id_cnt_next = id_cnt_reg;
        dlc_next    = dlc_reg;
        nb_next     = nb_reg;
        pay_next    = pay_reg;
        hi_next     = hi_reg;
        load        = 1'b0;
        cur.character = CHAR_CR;
        cur.last      = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                load = pop_valid;
            end
            PH_LETTER:
            begin
                cur.character = letter_reg;
                if (advance)
                    phase_next = PH_ID;
            end
            PH_ID:
            begin
                cur.character = hex_char(id_sh_reg[ID_SH_W-1 -: 4]);
                if (advance)
                begin
                    id_sh_next  = {id_sh_reg[ID_SH_W-5:0], 4'b0};
                    id_cnt_next = id_cnt_reg - 4'd1;
                    if (id_cnt_reg == 4'd1)
                        phase_next = PH_DLC;
                end
            end
            PH_DLC:
            begin
                cur.character = hex_char(dlc_reg);
                if (advance)
                begin
                    hi_next    = 1'b1;
                    phase_next = (nb_reg == '0) ? PH_CR : PH_DATA;
                end
            end
            PH_DATA:
            begin
                cur.character = hi_reg ? hex_char(pay_reg[7:4]) : hex_char(pay_reg[3:0]);
                if (advance)
                begin
                    hi_next = !hi_reg;
                    if (!hi_reg)
                    begin
                        pay_next = {8'b0, pay_reg[PAYLOAD_W-1:8]};
                        nb_next  = nb_reg - 4'd1;
                        if (nb_reg == 4'd1)
                            phase_next = PH_CR;
                    end
                end
            end
            PH_CR:
            begin
                cur.character = CHAR_CR;
                cur.last      = 1'b1;
                if (advance)
                begin
                    phase_next = PH_IDLE;
                    load       = pop_valid;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (load)
        begin
            phase_next  = PH_LETTER;
            letter_next = pop_desc.letter;
            id_sh_next  = pop_desc.id_sh;
            id_cnt_next = pop_desc.id_cnt;
            dlc_next    = pop_desc.dlc;
            nb_next     = pop_desc.nbytes;
            pay_next    = pop_desc.payload;
        end

        pop = load;

        out_next       = out_reg;
        out_valid_next = out_valid_reg && text_stall;
        if (advance)
        begin
            out_next       = cur;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
        id_sh_reg  <= id_sh_next;
        id_cnt_reg <= id_cnt_next;
        dlc_reg    <= dlc_next;
        nb_reg     <= nb_next;
        pay_reg    <= pay_next;
        hi_reg     <= hi_next;
        out_reg    <= out_next;
    end

    a_last_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.last |-> out_reg.character == CHAR_CR)
        else $error("last flag on a character other than carriage return");

    a_id_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ID |-> id_cnt_reg != '0)
        else $error("identifier phase with no digits left");

    a_nb_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> nb_reg != '0)
        else $error("data phase with no bytes left");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && text_stall |=> out_valid_reg && $stable(out_reg))
        else $error("stalled character changed");

endmodule

`default_nettype wire

// ===== rtl/slcan_frame_text_encoder_core.sv =====
// Throughput: one character per cycle while text_stall is low; consecutive frames follow
// without gaps, limited by the single character output register.
// A two-entry queue lets frames be accepted while the previous line is still being sent.
// Reset (rst_n, async, active low) empties all stages and clears output_enable to 0.
// Frames accepted while output_enable is 0 are dropped. Depends on slcan_pkg and submodules.
`default_nettype none

module slcan_frame_text_encoder_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data,
    input  wire logic              frame_valid,
    output logic                   frame_stall,
    input  wire slcan_pkg::frame_t frame,
    output logic                   text_valid,
    input  wire logic              text_stall,
    output slcan_pkg::text_t       text
);
    import slcan_pkg::*;

    logic   push_valid, push_ready;
    desc_t  push_desc;
    logic   pop_valid, pop;
    desc_t  pop_desc;

    assign cfg_ready = 1'b1;

    slcan_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_desc   (push_desc)
    );

    slcan_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_desc   (pop_desc)
    );

    slcan_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_desc   (pop_desc),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for slcan_frame_text_encoder_core: CAN frame requests in, ASCII line
// characters out, checked against an in-bench line encoder under random idling on both sides.
// Depends on slcan_pkg and the core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slcan_pkg::*;

    localparam int RANDOM_FRAMES = 230;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int MAX_REPORTS   = 10;
    localparam int N_DIR         = 20;

    typedef struct {
        frame_t req;
        string  line;
    } dir_row_t;

    // line is the text before the closing CR; empty means use the line encoder
    dir_row_t dir_rows [N_DIR] = '{
        '{'{29'h0000000, 1'b0, 1'b0, 4'h0, 64'h0}, "t0000"},
        '{'{29'h00007FF, 1'b0, 1'b0, 4'h8, 64'hFFFF_FFFF_FFFF_FFFF}, "t7FF8FFFFFFFFFFFFFFFF"},
        '{'{29'h1FFFFFFF, 1'b0, 1'b0, 4'h0, 64'h0}, "tFFF0"},
        '{'{29'h1FFFFFFF, 1'b1, 1'b0, 4'h0, 64'h0}, "T1FFFFFFF0"},
        '{'{29'h0000000, 1'b1, 1'b1, 4'h0, 64'h0}, "R000000000"},
        '{'{29'h0000123, 1'b0, 1'b1, 4'h8, 64'hFFFF_FFFF_FFFF_FFFF}, "r1238"},
        '{'{29'h0ABCDEF0, 1'b1, 1'b1, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF}, "R0ABCDEF0F"},
        '{'{29'h0000000, 1'b0, 1'b0, 4'h9, 64'h0123_4567_89AB_CDEF}, "t0009EFCDAB8967452301"},
        '{'{29'h12345678, 1'b1, 1'b0, 4'h8, 64'h0123_4567_89AB_CDEF},
          "T123456788EFCDAB8967452301"},
        '{'{29'h00000AA, 1'b0, 1'b0, 4'h1, 64'h5A}, "t0AA15A"},
        '{'{29'h1FFFFFFF, 1'b1, 1'b0, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF},
          "T1FFFFFFFFFFFFFFFFFFFFFFFF"},
        '{'{29'h0000800, 1'b0, 1'b0, 4'h2, 64'hA5A5}, ""},
        '{'{29'h10000000, 1'b1, 1'b0, 4'h3, 64'h00C0_FFEE}, ""},
        '{'{29'h00007FF, 1'b0, 1'b1, 4'hF, 64'h0}, ""},
        '{'{29'h0000555, 1'b0, 1'b0, 4'hA, 64'hAAAA_AAAA_AAAA_AAAA}, ""},
        '{'{29'h0AAAAAAA, 1'b1, 1'b0, 4'hB, 64'h5555_5555_5555_5555}, ""},
        '{'{29'h15555555, 1'b1, 1'b0, 4'h7, 64'h0011_2233_4455_6677}, ""},
        '{'{29'h00003C3, 1'b0, 1'b0, 4'h5, 64'h8899_AABB_CCDD_EEFF}, ""},
        '{'{29'h0000000, 1'b1, 1'b0, 4'hC, 64'hFEDC_BA98_7654_3210}, ""},
        '{'{29'h00001F0, 1'b0, 1'b1, 4'hD, 64'h1234}, ""}
    };

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   cfg_valid   = 1'b0;
    logic   cfg_ready;
    logic   cfg_data    = 1'b0;
    logic   frame_valid = 1'b0;
    logic   frame_stall;
    frame_t frame_req   = '0;
    logic   text_valid;
    logic   text_stall  = 1'b0;
    text_t  text_char;

    text_t  pending_chars [$];
    logic   output_on     = 1'b0;
    logic   back_to_back  = 1'b0;
    int     cycle_count   = 0;
    int     mismatches    = 0;
    int     chars_seen    = 0;
    int     lines_seen    = 0;
    int     frames_live   = 0;
    int     frames_muted  = 0;
    int     stall_left    = 0;
    int     run_left      = 0;

    slcan_frame_text_encoder_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame_req),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text        (text_char)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + {4'h0, v};
        return 8'h41 + {4'h0, v} - 8'd10;
    endfunction

    function automatic void queue_char(input logic [7:0] c, input logic is_last);
        text_t t;
        t.character = c;
        t.last      = is_last;
        pending_chars.push_back(t);
    endfunction

    // Expected text line for one accepted frame request
    function automatic void encode_line(input frame_t f);
        logic [31:0] id32;
        logic [7:0]  b;
        int          digits;
        int          nbytes;
        int          i;
        id32 = {3'b000, f.can_id};
        if (f.extended)
        begin
            queue_char(f.remote ? CHAR_EXT_RTR : CHAR_EXT_DATA, 1'b0);
            digits = 8;
        end
        else
        begin
            queue_char(f.remote ? CHAR_STD_RTR : CHAR_STD_DATA, 1'b0);
            digits = 3;
        end
        for (i = digits - 1; i >= 0; i--)
            queue_char(hex_digit(id32[4*i +: 4]), 1'b0);
        queue_char(hex_digit(f.length_code), 1'b0);
        if (!f.remote)
        begin
            nbytes = (f.length_code > 4'd8) ? 8 : int'(f.length_code);
            for (i = 0; i < nbytes; i++)
            begin
                b = f.payload[8*i +: 8];
                queue_char(hex_digit(b[7:4]), 1'b0);
                queue_char(hex_digit(b[3:0]), 1'b0);
            end
        end
        queue_char(CHAR_CR, 1'b1);
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        f.can_id      = ID_W'($urandom);
        f.extended    = 1'($urandom_range(0, 1));
        f.remote      = ($urandom_range(0, 3) == 0);
        f.length_code = ($urandom_range(0, 4) == 0) ? DLC_W'($urandom_range(9, 15))
                                                    : DLC_W'($urandom_range(0, 8));
        f.payload     = {$urandom, $urandom};
        return f;
    endfunction

    function automatic void report_mismatch(input string what, input text_t exp_c,
                                            input text_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                     $realtime, what, exp_c.character, exp_c.last,
                     got.character, got.last);
    endfunction

    // Frame request: random gap (none when back_to_back), then hold until accepted; valid stays high afterwards
    task automatic send_frame(input frame_t f, input string line);
        int gap;
        int i;
        gap = back_to_back ? 0 : pick_idle();
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_req   <= f;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
        if (!output_on)
            frames_muted++;
        else
        begin
            frames_live++;
            if (line.len() == 0)
                encode_line(f);
            else
            begin
                for (i = 0; i < line.len(); i++)
                    queue_char(line[i], 1'b0);
                queue_char(CHAR_CR, 1'b1);
            end
        end
    endtask

    task automatic settle_idle();
        frame_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_output_enable(input logic en);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        output_on = en;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            text_stall <= 1'b1;
            stall_left--;
        end
        else if (run_left > 0)
        begin
            text_stall <= 1'b0;
            run_left--;
        end
        else
        begin
            text_stall <= 1'b0;
            run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(0, 6);
            stall_left = pick_idle();
        end
    end

    always @(posedge clk)
    begin
        text_t exp_c;
        if (rst_n && text_valid && !text_stall)
        begin
            if (pending_chars.size() == 0)
                report_mismatch("unexpected character", '0, text_char);
            else
            begin
                exp_c = pending_chars.pop_front();
                if (text_char.character !== exp_c.character || text_char.last !== exp_c.last)
                    report_mismatch("character mismatch", exp_c, text_char);
            end
            chars_seen++;
            if (text_char.last)
                lines_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, pending_chars.size());
            $display("slcan_frame_text_encoder_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        int i;
        int n;
        int phase;
        logic en;
        phase = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // output is off out of reset: these requests must produce nothing
        for (i = 0; i < 4; i++)
            send_frame(random_frame(), "");
        settle_idle();

        write_output_enable(1'b1);
        for (i = 0; i < N_DIR; i++)
            send_frame(dir_rows[i].req, dir_rows[i].line);
        settle_idle();

        n = frames_live;
        while (frames_live - n < RANDOM_FRAMES)
        begin
            en = (phase % 4 != 2);
            back_to_back = (phase % 3 == 1);
            write_output_enable(en);
            repeat (en ? $urandom_range(25, 60) : $urandom_range(4, 10))
                send_frame(random_frame(), "");
            settle_idle();
            phase++;
        end
        write_output_enable(1'b0);
        send_frame(random_frame(), "");
        settle_idle();

        $display("covered %0d encoded frames and %0d dropped with output off",
                 frames_live, frames_muted);
        $display("checked %0d characters in %0d lines over %0d cycles, %0d mismatches",
                 chars_seen, lines_seen, cycle_count, mismatches);
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("slcan_frame_text_encoder_core regression: pass");
        else
            $display("slcan_frame_text_encoder_core regression: fail");
        $finish;
    end

endmodule
